// ===== hw/rtl/fps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants of the flight phase sequencer: field widths,
// phase codes, register indexes, register file and result records.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int ALT_BITS      = 20;
    localparam int ALT_OUT_BITS  = 19;
    localparam int THR_BITS      = 19;
    localparam int CONF_BITS     = 4;
    localparam int CNT_BITS      = 5;
    localparam int SERVO_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [ALT_BITS-1:0]   ALT_MAX       = ALT_BITS'(500000);
    localparam logic [CNT_BITS-1:0]   CNT_MAX       = '1;
    localparam logic [SERVO_BITS-1:0] SERVO_OPEN    = SERVO_BITS'(160);
    localparam logic [SERVO_BITS-1:0] SERVO_STOWED  = SERVO_BITS'(90);

    localparam logic signed [ALT_BITS-1:0] RST_REF_ALT  = '0;
    localparam logic [THR_BITS-1:0]        RST_ASC_THR  = THR_BITS'(1000);
    localparam logic [THR_BITS-1:0]        RST_HS_THR   = THR_BITS'(5000);
    localparam logic [THR_BITS-1:0]        RST_PC_THR   = THR_BITS'(2000);
    localparam logic [THR_BITS-1:0]        RST_LAND_THR = THR_BITS'(130);
    localparam logic [CONF_BITS-1:0]       RST_CONFIRM  = CONF_BITS'(4);

    localparam logic MODE_CALIBRATE = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT       = 3'd0,
        PH_ASCENT     = 3'd1,
        PH_DESCENT    = 3'd2,
        PH_HEATSHIELD = 3'd3,
        PH_PARACHUTE  = 3'd4,
        PH_LANDED     = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_REF_ALT  = 3'd0,
        CFG_ASC_THR  = 3'd1,
        CFG_HS_THR   = 3'd2,
        CFG_PC_THR   = 3'd3,
        CFG_LAND_THR = 3'd4,
        CFG_CONFIRM  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ALT_BITS-1:0] ref_alt;
        logic [THR_BITS-1:0]        asc_thr;
        logic [THR_BITS-1:0]        hs_thr;
        logic [THR_BITS-1:0]        pc_thr;
        logic [THR_BITS-1:0]        land_thr;
        logic [CONF_BITS-1:0]       confirm;
    } t_cfg;

    typedef struct packed {
        t_phase                  phase;
        logic [ALT_OUT_BITS-1:0] altitude;
        logic                    camera_start;
        logic                    heatshield_release;
        logic                    landed_pulse;
        logic                    heatshield_deployed;
        logic                    parachute_deployed;
        logic                    mast_raised;
        logic [SERVO_BITS-1:0]   servo_angle;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/fps_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fps_in_if
// Request channel: one altitude sample or a calibrate request.
// ----------------------------------------------------------------------------
interface fps_in_if;
    import fps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [ALT_BITS-1:0] raw_altitude;

    modport source (output valid, output mode, output raw_altitude, input ready);
    modport sink   (input valid, input mode, input raw_altitude, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fps_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fps_out_if
// Result channel: phase, corrected altitude, action pulses and deploy flags.
// ----------------------------------------------------------------------------
interface fps_out_if;
    import fps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [2:0]              phase;
    logic [ALT_OUT_BITS-1:0] altitude;
    logic                    camera_start;
    logic                    heatshield_release;
    logic                    landed_pulse;
    logic                    heatshield_deployed;
    logic                    parachute_deployed;
    logic                    mast_raised;
    logic [SERVO_BITS-1:0]   servo_angle;

    modport source (
        output valid, output phase, output altitude, output camera_start,
        output heatshield_release, output landed_pulse, output heatshield_deployed,
        output parachute_deployed, output mast_raised, output servo_angle,
        input ready
    );
    modport sink (
        input valid, input phase, input altitude, input camera_start,
        input heatshield_release, input landed_pulse, input heatshield_deployed,
        input parachute_deployed, input mast_raised, input servo_angle,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/fps_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fps_cfg_regs
// Configuration register file: reference altitude, phase thresholds and
// descent confirmation count, written through a plain write port.
// ----------------------------------------------------------------------------
module fps_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fps_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [fps_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output fps_pkg::t_cfg                           o_cfg
);
    import fps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_alt  <= RST_REF_ALT;
            r_cfg.asc_thr  <= RST_ASC_THR;
            r_cfg.hs_thr   <= RST_HS_THR;
            r_cfg.pc_thr   <= RST_PC_THR;
            r_cfg.land_thr <= RST_LAND_THR;
            r_cfg.confirm  <= RST_CONFIRM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REF_ALT:  r_cfg.ref_alt  <= $signed(i_cfg_data[ALT_BITS-1:0]);
                CFG_ASC_THR:  r_cfg.asc_thr  <= i_cfg_data[THR_BITS-1:0];
                CFG_HS_THR:   r_cfg.hs_thr   <= i_cfg_data[THR_BITS-1:0];
                CFG_PC_THR:   r_cfg.pc_thr   <= i_cfg_data[THR_BITS-1:0];
                CFG_LAND_THR: r_cfg.land_thr <= i_cfg_data[THR_BITS-1:0];
                CFG_CONFIRM:  r_cfg.confirm  <= i_cfg_data[CONF_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== hw/rtl/fps_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fps_core
// Altitude correction and clamp, six-phase flight sequencer with its falling
// counter and deploy flags; state advances on each step strobe.
// ----------------------------------------------------------------------------
module fps_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_step,
    input  wire logic                              i_mode,
    input  wire logic signed [fps_pkg::ALT_BITS-1:0] i_raw_altitude,
    input  wire fps_pkg::t_cfg                     i_cfg,
    output fps_pkg::t_result                       o_result
);
    import fps_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [ALT_OUT_BITS-1:0] r_prev_alt, n_prev_alt;
    logic [CNT_BITS-1:0]     r_fall_cnt, n_fall_cnt;
    logic                    r_hs_flag, n_hs_flag;
    logic                    r_pc_flag, n_pc_flag;
    logic                    r_mast_flag, n_mast_flag;

    logic [ALT_BITS:0]       w_diff;
    logic [ALT_OUT_BITS-1:0] w_alt;
    logic [CNT_BITS-1:0]     w_cnt_inc;
    logic                    w_cam, w_hs_pulse, w_land;

    // corrected and clamped altitude
    always_comb begin
        w_diff = {i_raw_altitude[ALT_BITS-1], i_raw_altitude}
               - {i_cfg.ref_alt[ALT_BITS-1], i_cfg.ref_alt};
        if (w_diff[ALT_BITS]) begin
            w_alt = '0;
        end else if (w_diff[ALT_BITS-1:0] > ALT_MAX) begin
            w_alt = ALT_MAX[ALT_OUT_BITS-1:0];
        end else begin
            w_alt = w_diff[ALT_OUT_BITS-1:0];
        end
    end

    assign w_cnt_inc = (r_fall_cnt == CNT_MAX) ? r_fall_cnt : r_fall_cnt + 1'b1;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_fall_cnt = r_fall_cnt;
        if (i_mode == MODE_CALIBRATE) begin
            n_phase = PH_WAIT;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (w_alt > i_cfg.asc_thr) n_phase = PH_ASCENT;
                end
                PH_ASCENT: begin
                    if (w_alt < r_prev_alt) begin
                        if (w_cnt_inc > {1'b0, i_cfg.confirm}) begin
                            n_phase    = PH_DESCENT;
                            n_fall_cnt = '0;
                        end else begin
                            n_fall_cnt = w_cnt_inc;
                        end
                    end
                end
                PH_DESCENT: begin
                    if (w_alt < i_cfg.hs_thr) n_phase = PH_HEATSHIELD;
                end
                PH_HEATSHIELD: begin
                    if (w_alt < i_cfg.pc_thr) n_phase = PH_PARACHUTE;
                end
                PH_PARACHUTE: begin
                    if (w_alt < i_cfg.land_thr) n_phase = PH_LANDED;
                end
                PH_LANDED: ;
                default: ;
            endcase
        end
    end

    // outputs: entry pulses, flags, result record
    always_comb begin
        w_cam      = (r_phase == PH_ASCENT) && (n_phase == PH_DESCENT);
        w_hs_pulse = (r_phase == PH_DESCENT) && (n_phase == PH_HEATSHIELD);
        w_land     = (r_phase == PH_PARACHUTE) && (n_phase == PH_LANDED);
        if (i_mode == MODE_CALIBRATE) begin
            n_hs_flag   = 1'b0;
            n_pc_flag   = 1'b0;
            n_mast_flag = 1'b0;
            n_prev_alt  = r_prev_alt;
        end else begin
            n_hs_flag   = r_hs_flag | w_hs_pulse;
            n_pc_flag   = r_pc_flag | ((r_phase == PH_HEATSHIELD) && (n_phase == PH_PARACHUTE));
            n_mast_flag = r_mast_flag | w_land;
            n_prev_alt  = w_alt;
        end
        o_result.phase               = n_phase;
        o_result.altitude            = n_prev_alt;
        o_result.camera_start        = w_cam;
        o_result.heatshield_release  = w_hs_pulse;
        o_result.landed_pulse        = w_land;
        o_result.heatshield_deployed = n_hs_flag;
        o_result.parachute_deployed  = n_pc_flag;
        o_result.mast_raised         = n_mast_flag;
        o_result.servo_angle         = n_pc_flag ? SERVO_OPEN : SERVO_STOWED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_prev_alt  <= '0;
            r_fall_cnt  <= '0;
            r_hs_flag   <= 1'b0;
            r_pc_flag   <= 1'b0;
            r_mast_flag <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_prev_alt  <= n_prev_alt;
            r_fall_cnt  <= n_fall_cnt;
            r_hs_flag   <= n_hs_flag;
            r_pc_flag   <= n_pc_flag;
            r_mast_flag <= n_mast_flag;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/flight_phase_sequencer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flight_phase_sequencer_top
// Flight phase sequencer: altitude samples in, phase, altitude and deploy
// actions out, with a configuration register file.
//
//   channel   dir  handshake        payload
//   i_req     in   valid / ready    mode, raw_altitude
//   o_res     out  valid / ready    phase, altitude, pulses, flags, servo_angle
//   i_cfg_*   in   write enable     register index, write data
//
// one request per cycle sustained while o_res is ready; a request lands in the
// input register when it is taken, and its result is loaded into the result
// register, and is valid there, as the request leaves the input register
// the sequencer state updates as a request leaves the input register, so
// back-to-back requests see each other's state
// o_res stalls hold the result register; i_req stays ready while the input
// register is empty or moving; synchronous active-low reset, nothing to sweep
// ----------------------------------------------------------------------------
module flight_phase_sequencer_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    fps_in_if.sink                                 i_req,
    fps_out_if.source                              o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [fps_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [fps_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import fps_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;

    logic                       r_in_valid;
    logic                       r_in_mode;
    logic signed [ALT_BITS-1:0] r_in_raw;
    logic                       r_out_valid;
    t_result                    r_out;
    logic                       w_adv;

    fps_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    fps_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_adv),
        .i_mode         (r_in_mode),
        .i_raw_altitude (r_in_raw),
        .i_cfg          (w_cfg),
        .o_result       (w_result)
    );

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_mode <= i_req.mode;
            r_in_raw  <= i_req.raw_altitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.phase               = r_out.phase;
    assign o_res.altitude            = r_out.altitude;
    assign o_res.camera_start        = r_out.camera_start;
    assign o_res.heatshield_release  = r_out.heatshield_release;
    assign o_res.landed_pulse        = r_out.landed_pulse;
    assign o_res.heatshield_deployed = r_out.heatshield_deployed;
    assign o_res.parachute_deployed  = r_out.parachute_deployed;
    assign o_res.mast_raised         = r_out.mast_raised;
    assign o_res.servo_angle         = r_out.servo_angle;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_raw) && $stable(r_in_mode))
        else $error("input register changed while stalled");

    a_land_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.landed_pulse |-> r_out.mast_raised && r_out.phase == PH_LANDED)
        else $error("landing pulse without mast flag or landed phase");

    a_servo_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.servo_angle == SERVO_OPEN) == r_out.parachute_deployed))
        else $error("servo angle disagrees with parachute flag");

endmodule
`default_nettype wire
